/* sv/pol_pkg.sv */
// shared types and codes for the positional ordered list
// command kinds, status codes and the result record
// no dependencies
package pol_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_INS_POS  = 3'd2,
    KIND_DEL_HEAD = 3'd3,
    KIND_DEL_TAIL = 3'd4,
    KIND_DEL_POS  = 3'd5,
    KIND_DUMP     = 3'd6
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    status_e                  status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } res_t;

endpackage

/* sv/positional_ordered_list_core.sv */
// top level of the positional ordered list
// instantiates pol_seq and pol_mem; uses pol_pkg
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | request   | in_valid_i / in_stall_o | kind_i, value_i, position_i
//  out     | result    | out_valid_o/out_stall_i | element_o, element_valid_o,
//          |           |                        | status_o, length_o, last_o
//
// one request at a time; the next is taken once the last result of the
// current one sits in the output register, even if that is still stalled
// positional insert: entries shift up in S_INS_SH, S_INS_PUT writes the value;
// positional delete: moved entries shift down in S_DEL_SH; nothing moved: S_RESP
// dump: one element per cycle, paced by out_stall_i; other requests go to S_RESP
// rst_ni clears the state, the entry count and the output valid only; the store is never read beyond the count
module positional_ordered_list_core #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pol_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [pol_pkg::DATA_W-1:0] value_i,
  input  logic [pol_pkg::POS_W-1:0]         position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pol_pkg::DATA_W-1:0] element_o,
  output logic                              element_valid_o,
  output logic [pol_pkg::STAT_W-1:0]        status_o,
  output logic [pol_pkg::LEN_W-1:0]         length_o,
  output logic                              last_o
);

  // address of an entry, and a count that can reach capacity itself
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                       mem_ren;
  logic [AW-1:0]              mem_raddr;
  logic                       mem_wen;
  logic [AW-1:0]              mem_waddr;
  logic [pol_pkg::DATA_W-1:0] mem_wdata;
  logic [pol_pkg::DATA_W-1:0] mem_rdata;
  pol_pkg::res_t              res;

  // sequencer: decode, shift loops, dump stream and result register
  pol_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .mem_ren_o   (mem_ren),
    .mem_raddr_o (mem_raddr),
    .mem_wen_o   (mem_wen),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // entry store, head at address zero
  pol_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ren_i   (mem_ren),
    .raddr_i (mem_raddr),
    .wen_i   (mem_wen),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // result record out to the ports
  assign element_o       = res.element;
  assign element_valid_o = res.element_valid;
  assign status_o        = res.status;
  assign length_o        = res.length;
  assign last_o          = res.last;

endmodule

/* sv/pol_mem.sv */
// entry store: single write port, one read port with registered data
// uses pol_pkg for the data width
module pol_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk_i,
  input  logic                      ren_i,
  input  logic [AW-1:0]             raddr_i,
  input  logic                      wen_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [pol_pkg::DATA_W-1:0] wdata_i,
  output logic [pol_pkg::DATA_W-1:0] rdata_o
);

  logic [pol_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [pol_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wen_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (ren_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pol_seq.sv */
// command sequencer: decodes a request, shifts entries through the store,
// streams dumps and holds the result register
// uses pol_pkg; drives pol_mem
module pol_seq #(
  parameter int CAPACITY = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pol_pkg::KIND_W-1:0]  kind_i,
  input  logic [pol_pkg::DATA_W-1:0]  value_i,
  input  logic [pol_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pol_pkg::res_t               res_o,
  output logic                        mem_ren_o,
  output logic [AW-1:0]               mem_raddr_o,
  output logic                        mem_wen_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [pol_pkg::DATA_W-1:0]  mem_wdata_o,
  input  logic [pol_pkg::DATA_W-1:0]  mem_rdata_i
);

  localparam int CMPW = (CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SH,
    S_INS_PUT,
    S_DEL_SH,
    S_DUMP,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic [AW-1:0]               end_q, end_d;
  logic [pol_pkg::DATA_W-1:0]  val_q, val_d;
  pol_pkg::status_e            st_q, st_d;
  logic                        out_vld_q, out_vld_d;
  pol_pkg::res_t               out_q, out_d;

  logic                        accept;
  logic                        out_free;
  logic [CMPW-1:0]             n_x;
  logic [CMPW-1:0]             p_x;
  logic [CMPW-1:0]             nm1_x;
  logic [CMPW-1:0]             pp1_x;
  logic [CMPW-1:0]             cnt_x;
  logic                        is_ins;
  logic                        is_del;
  pol_pkg::kind_e              kind;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;
  assign kind     = pol_pkg::kind_e'(kind_i);
  assign n_x      = CMPW'(cnt_q);
  assign nm1_x    = n_x - CMPW'(1);
  assign pp1_x    = p_x + CMPW'(1);
  assign cnt_x    = CMPW'(cnt_q);

  // target position per command kind
  always_comb begin
    p_x    = CMPW'(position_i);
    is_ins = 1'b0;
    is_del = 1'b0;
    case (kind)
      pol_pkg::KIND_INS_HEAD: begin
        p_x    = '0;
        is_ins = 1'b1;
      end
      pol_pkg::KIND_INS_TAIL: begin
        p_x    = n_x;
        is_ins = 1'b1;
      end
      pol_pkg::KIND_INS_POS: begin
        is_ins = 1'b1;
      end
      pol_pkg::KIND_DEL_HEAD: begin
        p_x    = '0;
        is_del = 1'b1;
      end
      pol_pkg::KIND_DEL_TAIL: begin
        p_x    = nm1_x;
        is_del = 1'b1;
      end
      pol_pkg::KIND_DEL_POS: begin
        is_del = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    end_d       = end_q;
    val_d       = val_q;
    st_d        = st_q;
    out_vld_d   = out_vld_q && out_stall_i;
    out_d       = out_q;
    mem_ren_o   = 1'b0;
    mem_raddr_o = idx_q;
    mem_wen_o   = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d   = value_i;
          pos_d   = p_x[AW-1:0];
          end_d   = nm1_x[AW-1:0];
          st_d    = pol_pkg::ST_OK;
          state_d = S_RESP;
          if (is_ins) begin
            if (cnt_q == CW'(CAPACITY)) begin
              st_d = pol_pkg::ST_FULL;
            end else if (p_x > n_x) begin
              st_d = pol_pkg::ST_BADPOS;
            end else begin
              cnt_d = cnt_q + CW'(1);
              if (p_x == n_x) begin
                mem_wen_o   = 1'b1;
                mem_waddr_o = n_x[AW-1:0];
                mem_wdata_o = value_i;
              end else begin
                mem_ren_o   = 1'b1;
                mem_raddr_o = nm1_x[AW-1:0];
                idx_d       = nm1_x[AW-1:0];
                state_d     = S_INS_SH;
              end
            end
          end else if (is_del) begin
            if (cnt_q == '0) begin
              st_d = pol_pkg::ST_EMPTY;
            end else if (p_x >= n_x) begin
              st_d = pol_pkg::ST_BADPOS;
            end else begin
              cnt_d = cnt_q - CW'(1);
              if (p_x != nm1_x) begin
                mem_ren_o   = 1'b1;
                mem_raddr_o = pp1_x[AW-1:0];
                idx_d       = pp1_x[AW-1:0];
                state_d     = S_DEL_SH;
              end
            end
          end else if (kind == pol_pkg::KIND_DUMP) begin
            if (cnt_q == '0) begin
              st_d = pol_pkg::ST_EMPTY;
            end else begin
              mem_ren_o   = 1'b1;
              mem_raddr_o = '0;
              idx_d       = '0;
              state_d     = S_DUMP;
            end
          end else begin
            st_d = pol_pkg::ST_BADPOS;
          end
        end
      end

      // move entry idx up by one, walking down towards the insert point
      S_INS_SH: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = idx_q + AW'(1);
        if (idx_q == pos_q) begin
          state_d = S_INS_PUT;
        end else begin
          mem_ren_o   = 1'b1;
          mem_raddr_o = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end

      S_INS_PUT: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        state_d     = S_RESP;
      end

      // move entry idx down by one, walking up to the old tail
      S_DEL_SH: begin
        mem_wen_o   = 1'b1;
        mem_waddr_o = idx_q - AW'(1);
        if (idx_q == end_q) begin
          state_d = S_RESP;
        end else begin
          mem_ren_o   = 1'b1;
          mem_raddr_o = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
        end
      end

      // read data for idx is waiting; next read goes out as it is taken
      S_DUMP: begin
        if (out_free) begin
          out_vld_d           = 1'b1;
          out_d.element       = mem_rdata_i;
          out_d.element_valid = 1'b1;
          out_d.status        = pol_pkg::ST_OK;
          out_d.length        = cnt_x[pol_pkg::LEN_W-1:0];
          out_d.last          = (idx_q == end_q);
          if (idx_q == end_q) begin
            state_d = S_IDLE;
          end else begin
            mem_ren_o   = 1'b1;
            mem_raddr_o = idx_q + AW'(1);
            idx_d       = idx_q + AW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_vld_d           = 1'b1;
          out_d.element       = '0;
          out_d.element_valid = 1'b0;
          out_d.status        = st_q;
          out_d.length        = cnt_x[pol_pkg::LEN_W-1:0];
          out_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    end_q <= end_d;
    val_q <= val_d;
    st_q  <= st_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

/* sv/pol_chk.sv */
// port-level checks for the positional ordered list, bound to the top level
// uses pol_pkg for status codes
module pol_chk #(
  parameter int CAPACITY = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [pol_pkg::DATA_W-1:0] element_o,
  input logic                              element_valid_o,
  input logic [pol_pkg::STAT_W-1:0]        status_o,
  input logic [pol_pkg::LEN_W-1:0]         length_o,
  input logic                              last_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_o) &&
      $stable(status_o) && $stable(length_o) && $stable(last_o))
    else $error("stalled result changed");

  // a dumped element always carries an ok status
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_valid_o |-> status_o == pol_pkg::ST_OK)
    else $error("dump element without ok status");

  // a result without an element closes its request and shows zero
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !element_valid_o |-> last_o && element_o == '0)
    else $error("single result not marked last");

  // full refusal only at capacity, empty only at zero length
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pol_pkg::ST_FULL |->
      length_o == pol_pkg::LEN_W'(CAPACITY))
    else $error("full status below capacity");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pol_pkg::ST_EMPTY |-> length_o == '0)
    else $error("empty status with entries present");

endmodule

bind positional_ordered_list_core pol_chk #(.CAPACITY(CAPACITY)) u_pol_chk (.*);
